### rtl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the status frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0]  HDR_BYTE     = 8'h24;
  localparam logic [7:0]  FTR_BYTE     = 8'h25;
  localparam logic [7:0]  TYPE_CUP     = 8'hA1;
  localparam logic [7:0]  TYPE_OUTLET  = 8'hA5;
  localparam logic [7:0]  TYPE_DOOR    = 8'hAA;
  localparam logic [14:0] MAXLEN_RESET = 15'd10000;

  localparam int CAPTURE_DEPTH_DEF = 26;
  localparam int SNAP_BYTES        = 26;

  localparam logic [1:0] KIND_CUP    = 2'd0;
  localparam logic [1:0] KIND_OUTLET = 2'd1;
  localparam logic [1:0] KIND_DOOR   = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  typedef struct packed {
    logic                         valid;
    logic [SNAP_BYTES-1:0][7:0]   bytes;
  } frame_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [1:0]  unit_index;
    logic [7:0]  link_status;
    logic [7:0]  value_a;
    logic [7:0]  value_b;
    logic [7:0]  value_c;
    logic [7:0]  value_d;
    logic [7:0]  value_e;
    logic [39:0] outlet_states;
    logic [39:0] outlet_sensors;
    logic [39:0] outlet_locks;
    logic        last_record;
  } rec_t;

endpackage

### rtl/sfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_if
// Channel interfaces: received bytes, result records, configuration writes.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [1:0]  unit_index;
  logic [7:0]  link_status;
  logic [7:0]  value_a;
  logic [7:0]  value_b;
  logic [7:0]  value_c;
  logic [7:0]  value_d;
  logic [7:0]  value_e;
  logic [39:0] outlet_states;
  logic [39:0] outlet_sensors;
  logic [39:0] outlet_locks;
  logic        last_record;

  modport source (output valid, output record_kind, output unit_index, output link_status,
                  output value_a, output value_b, output value_c, output value_d,
                  output value_e, output outlet_states, output outlet_sensors,
                  output outlet_locks, output last_record, input ready);
  modport sink   (input valid, input record_kind, input unit_index, input link_status,
                  input value_a, input value_b, input value_c, input value_d,
                  input value_e, input outlet_states, input outlet_sensors,
                  input outlet_locks, input last_record, output ready);
endinterface

interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] max_frame_length;

  modport source (output valid, output max_frame_length, input ready);
  modport sink   (input valid, input max_frame_length, output ready);
endinterface

### rtl/sfd_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_deframer
// Header hunt, length check, capture, footer check: one byte per ready cycle.
// ----------------------------------------------------------------------------
module sfd_deframer #(
  parameter int CAPTURE_DEPTH = sfd_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  sfd_byte_if.sink        in_ch,
  sfd_cfg_if.sink         cfg_ch,
  output sfd_pkg::frame_t frm,
  input  logic            frm_ready
);

  localparam int          IDX_W   = $clog2(CAPTURE_DEPTH);
  localparam logic [14:0] DEPTH15 = 15'(CAPTURE_DEPTH);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENLO,
    PH_LENHI,
    PH_BODY
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [14:0]                   frame_length_r, frame_length_nxt;
  logic [14:0]                   byte_pos_r, byte_pos_nxt;
  logic [14:0]                   max_len_r;
  logic [CAPTURE_DEPTH-1:0][7:0] capture_r, capture_nxt;

  logic        accept;
  logic        last_pos;
  logic [7:0]  b;
  logic [7:0]  lo;
  logic [14:0] len;
  logic [14:0] wr_pos;
  logic        done;

  assign b        = in_ch.rx_byte;
  assign lo       = frame_length_r[7:0];
  assign len      = {b[6:0], lo};
  assign wr_pos   = byte_pos_r - 15'd1;
  assign last_pos = ({1'b0, byte_pos_r} + 16'd1) >= {1'b0, frame_length_r};

  assign in_ch.ready  = !((phase_r == PH_BODY) && last_pos && !frm_ready);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    byte_pos_nxt     = byte_pos_r;
    capture_nxt      = capture_r;
    done             = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (b == sfd_pkg::HDR_BYTE) begin
            capture_nxt = '0;
            phase_nxt   = PH_LENLO;
          end
        end
        PH_LENLO: begin
          frame_length_nxt = {7'd0, b};
          phase_nxt        = PH_LENHI;
        end
        PH_LENHI: begin
          if (b[7] || (len > max_len_r)) begin
            // rescan the two length bytes for a header
            if (lo == sfd_pkg::HDR_BYTE) begin
              capture_nxt      = '0;
              frame_length_nxt = {7'd0, b};
              phase_nxt        = PH_LENHI;
            end else if (b == sfd_pkg::HDR_BYTE) begin
              capture_nxt      = '0;
              frame_length_nxt = '0;
              phase_nxt        = PH_LENLO;
            end else begin
              frame_length_nxt = '0;
              phase_nxt        = PH_HUNT;
            end
          end else begin
            frame_length_nxt = len;
            byte_pos_nxt     = '0;
            phase_nxt        = (len == 15'd0) ? PH_HUNT : PH_BODY;
          end
        end
        PH_BODY: begin
          if ((byte_pos_r != 15'd0) && (wr_pos < DEPTH15)) begin
            capture_nxt[wr_pos[IDX_W-1:0]] = b;
          end
          if (last_pos) begin
            phase_nxt    = PH_HUNT;
            byte_pos_nxt = '0;
            done         = (b == sfd_pkg::FTR_BYTE);
          end else begin
            byte_pos_nxt = byte_pos_r + 15'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  assign frm.valid = done;
  assign frm.bytes = capture_nxt[sfd_pkg::SNAP_BYTES-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_length_r <= '0;
      byte_pos_r     <= '0;
      capture_r      <= '0;
      max_len_r      <= sfd_pkg::MAXLEN_RESET;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      byte_pos_r     <= byte_pos_nxt;
      capture_r      <= capture_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_len_r <= cfg_ch.max_frame_length;
      end
    end
  end

endmodule

### rtl/sfd_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_emitter
// Holds a good frame and issues its records through the output register.
// ----------------------------------------------------------------------------
module sfd_emitter (
  input  logic            clk,
  input  logic            rst_n,
  input  sfd_pkg::frame_t frm,
  output logic            frm_ready,
  sfd_rec_if.source       out_ch
);

  logic [sfd_pkg::SNAP_BYTES-1:0][7:0] snap_r;
  logic                                snap_valid_r;
  logic [1:0]                          rec_idx_r;
  logic                                out_valid_r;
  sfd_pkg::rec_t                       out_rec_r;

  sfd_pkg::rec_t rec;
  logic [1:0]    kind;
  logic          last;
  logic          load;

  always_comb begin
    case (snap_r[1])
      sfd_pkg::TYPE_CUP:    kind = sfd_pkg::KIND_CUP;
      sfd_pkg::TYPE_OUTLET: kind = sfd_pkg::KIND_OUTLET;
      sfd_pkg::TYPE_DOOR:   kind = sfd_pkg::KIND_DOOR;
      default:              kind = sfd_pkg::KIND_OTHER;
    endcase
  end

  assign last = (kind != sfd_pkg::KIND_CUP) || (rec_idx_r == 2'd3);

  always_comb begin
    rec             = '0;
    rec.record_kind = kind;
    rec.last_record = last;
    case (kind)
      sfd_pkg::KIND_CUP: begin
        rec.unit_index = rec_idx_r;
        for (int i = 0; i < 4; i++) begin
          if (rec_idx_r == 2'(i)) begin
            rec.link_status = snap_r[2 + 6 * i];
            rec.value_a     = snap_r[3 + 6 * i];
            rec.value_b     = snap_r[4 + 6 * i];
            rec.value_c     = snap_r[5 + 6 * i];
            rec.value_d     = snap_r[6 + 6 * i];
            rec.value_e     = snap_r[7 + 6 * i];
          end
        end
      end
      sfd_pkg::KIND_OUTLET: begin
        rec.link_status    = snap_r[2];
        rec.outlet_states  = {snap_r[7], snap_r[6], snap_r[5], snap_r[4], snap_r[3]};
        rec.outlet_sensors = {snap_r[12], snap_r[11], snap_r[10], snap_r[9], snap_r[8]};
        rec.outlet_locks   = {snap_r[17], snap_r[16], snap_r[15], snap_r[14], snap_r[13]};
      end
      sfd_pkg::KIND_DOOR: begin
        rec.link_status = 8'd1;
        rec.value_a     = {7'd0, (snap_r[3] == 8'd0)};
        rec.value_b     = {7'd0, (snap_r[4] == 8'd0)};
      end
      default: begin
        rec.unit_index = 2'd0;
      end
    endcase
  end

  assign load      = snap_valid_r && (!out_valid_r || out_ch.ready);
  assign frm_ready = !snap_valid_r || (load && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      rec_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (frm.valid && frm_ready) begin
        snap_valid_r <= 1'b1;
        rec_idx_r    <= '0;
      end else if (load) begin
        snap_valid_r <= !last;
        rec_idx_r    <= rec_idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm.valid && frm_ready) begin
      snap_r <= frm.bytes;
    end
    if (load) begin
      out_rec_r <= rec;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.record_kind    = out_rec_r.record_kind;
  assign out_ch.unit_index     = out_rec_r.unit_index;
  assign out_ch.link_status    = out_rec_r.link_status;
  assign out_ch.value_a        = out_rec_r.value_a;
  assign out_ch.value_b        = out_rec_r.value_b;
  assign out_ch.value_c        = out_rec_r.value_c;
  assign out_ch.value_d        = out_rec_r.value_d;
  assign out_ch.value_e        = out_rec_r.value_e;
  assign out_ch.outlet_states  = out_rec_r.outlet_states;
  assign out_ch.outlet_sensors = out_rec_r.outlet_sensors;
  assign out_ch.outlet_locks   = out_rec_r.outlet_locks;
  assign out_ch.last_record    = out_rec_r.last_record;

endmodule

### rtl/status_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_frame_deframer_top
// Status frame deframer: byte stream in, decoded status records out.
//
// in_ch takes one received byte per transaction, one per cycle at full rate.
// cfg_ch writes max_frame_length (reset 10000); write only while idle.
// out_ch carries records: four cup-unit records for a cup frame, one record
// for any other good frame, last_record set on the final one.
// On the footer byte a good frame goes into the snapshot, then its first
// record to the output register; cup records go one per cycle on out_ch ready.
// A finished frame is held in a snapshot stage so bytes of the next frame
// keep flowing while records drain; in_ch stalls only on a frame's last byte
// while the snapshot still holds records not yet moved to the output.
// When out_ch stalls, the output register holds its record.
// Reset (rst_n low at a clock edge) returns to header hunt, clears the
// capture buffer and drops any pending records.
// ----------------------------------------------------------------------------
module status_frame_deframer_top #(
  parameter int CAPTURE_DEPTH = sfd_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sfd_byte_if.sink  in_ch,
  sfd_cfg_if.sink   cfg_ch,
  sfd_rec_if.source out_ch
);

  sfd_pkg::frame_t frm;
  logic            frm_ready;

  sfd_deframer #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .frm      (frm),
    .frm_ready(frm_ready)
  );

  sfd_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm      (frm),
    .frm_ready(frm_ready),
    .out_ch   (out_ch)
  );

endmodule
